// File: rtl/core/pftr_pkg.sv
// ----------------------------------------------------------------------------
// Poll fallback retry table package
// Shared sizes, operation codes, protocol levels, poll codes and the types
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pftr_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W     = 8;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned SLOTS       = 4;

  // Operation codes.
  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_GET        = 3'd1;
  localparam logic [2:0] OP_FAIL       = 3'd2;
  localparam logic [2:0] OP_SUCCESS    = 3'd3;
  localparam logic [2:0] OP_RESET_ALL  = 3'd4;
  localparam logic [2:0] OP_DEACTIVATE = 3'd5;

  // Protocol levels for the deactivate sweep.
  localparam logic [1:0] LVL_5X = 2'd0;
  localparam logic [1:0] LVL_4X = 2'd1;
  localparam logic [1:0] LVL_3X = 2'd2;

  // Poll codes examined by the deactivate sweep.
  localparam logic [CODE_W-1:0] CODE_6F = 8'h6F;
  localparam logic [CODE_W-1:0] CODE_2F = 8'h2F;
  localparam logic [CODE_W-1:0] CODE_2A = 8'h2A;
  localparam logic [CODE_W-1:0] CODE_2B = 8'h2B;

  // Reset value of the retry register.
  localparam logic [CNT_W-1:0] RETRY_RESET = 4'd3;

  // One stored table entry.
  typedef struct packed {
    logic                      success;
    logic [SLOTS*CNT_W-1:0]    retry;
    logic [SLOTS*CODE_W-1:0]   codes;
  } pftr_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_input;
    logic rd_sweep;
    logic wr_single;
    logic wr_sweep;
    logic sweep_clr;
    logic sweep_inc;
    logic out_single;
    logic out_zero;
  } pftr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } pftr_stat_t;

endpackage

// File: rtl/core/pftr_dpath.sv
// ----------------------------------------------------------------------------
// Poll fallback retry table datapath
// Holds the entry memory, the presence bits, the retry register, the sweep
// counter and the result register, and carries out each command.
// ----------------------------------------------------------------------------
module pftr_dpath import pftr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pftr_cmd_t           cmd_i,
  output pftr_stat_t          stat_o,
  input  logic                cfg_valid_i,
  input  logic [CNT_W-1:0]    cfg_data_i,
  input  logic [2:0]          opcode_i,
  input  logic [ENTRY_W-1:0]  entry_index_i,
  input  logic [CODE_W-1:0]   primary_code_i,
  input  logic [CODE_W-1:0]   secondary_code_i,
  input  logic [CODE_W-1:0]   fallback_code_i,
  input  logic [CODE_W-1:0]   last_fallback_code_i,
  input  logic [1:0]          protocol_level_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                entry_found_o,
  output logic                poll_valid_o,
  output logic [CODE_W-1:0]   poll_code_o
);

  logic [CNT_W-1:0]          retry_q;
  logic [2:0]                op_q;
  logic [ENTRY_W-1:0]        idx_q;
  logic [SLOTS*CODE_W-1:0]   codes_q;
  logic [1:0]                level_q;
  logic [IDX_W-1:0]          sweep_q;
  logic [TABLE_DEPTH-1:0]    present_q;
  pftr_entry_t               mem_q [TABLE_DEPTH];
  pftr_entry_t               rd_q;

  logic                      out_valid_q;
  logic                      out_valid_d;
  logic                      found_q;
  logic                      pvalid_q;
  logic [CODE_W-1:0]         pcode_q;

  logic [SLOTS*CNT_W-1:0]    full_cnt;
  logic                      in_range;
  logic                      found;
  logic                      live_any;
  logic [1:0]                live_sel;
  logic [CNT_W-1:0]          live_cnt;

  pftr_entry_t               sg_rec;
  logic                      sg_we;
  logic                      sg_set;
  logic                      sg_found;
  logic                      sg_valid;
  logic [CODE_W-1:0]         sg_code;
  pftr_entry_t               sw_rec;

  logic                      mem_we;
  logic                      mem_re;
  logic [IDX_W-1:0]          mem_waddr;
  logic [IDX_W-1:0]          mem_raddr;
  pftr_entry_t               mem_wdata;

  // Retry register, written whenever a configuration transaction arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= RETRY_RESET;
    end else if (cfg_valid_i) begin
      retry_q <= cfg_data_i;
    end
  end

  assign full_cnt = {SLOTS{retry_q}};

  // Capture the accepted input transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      idx_q   <= entry_index_i;
      codes_q <= {last_fallback_code_i, fallback_code_i, secondary_code_i, primary_code_i};
      level_q <= protocol_level_i;
    end
  end

  // Sweep counter walks every entry for reset-all and deactivate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_clr) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_inc) begin
      sweep_q <= sweep_q + IDX_W'(1);
    end
  end

  assign stat_o.sweep_last = (sweep_q == IDX_W'(TABLE_DEPTH - 1));

  // Presence bits, one per entry, cleared by reset and set by add.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cmd_i.wr_single && sg_set) begin
      present_q[idx_q[IDX_W-1:0]] <= 1'b1;
    end
  end

  assign in_range = ({1'b0, idx_q} < (ENTRY_W + 1)'(TABLE_DEPTH));
  assign found    = in_range && present_q[idx_q[IDX_W-1:0]];

  // First slot whose counter is still nonzero.
  always_comb begin
    live_any = 1'b1;
    live_sel = 2'd0;
    if (rd_q.retry[0*CNT_W +: CNT_W] != '0) begin
      live_sel = 2'd0;
    end else if (rd_q.retry[1*CNT_W +: CNT_W] != '0) begin
      live_sel = 2'd1;
    end else if (rd_q.retry[2*CNT_W +: CNT_W] != '0) begin
      live_sel = 2'd2;
    end else if (rd_q.retry[3*CNT_W +: CNT_W] != '0) begin
      live_sel = 2'd3;
    end else begin
      live_any = 1'b0;
    end
  end

  assign live_cnt = rd_q.retry[CNT_W*live_sel +: CNT_W];

  // Single-entry operations: new entry contents and the result.
  always_comb begin
    sg_rec   = rd_q;
    sg_we    = 1'b0;
    sg_set   = 1'b0;
    sg_found = 1'b0;
    sg_valid = 1'b0;
    sg_code  = '0;
    unique case (op_q)
      OP_ADD: begin
        if (in_range) begin
          sg_rec.success = 1'b0;
          sg_rec.retry   = full_cnt;
          sg_rec.codes   = codes_q;
          sg_we          = 1'b1;
          sg_set         = 1'b1;
          sg_found       = 1'b1;
        end
      end
      OP_GET: begin
        sg_found = found;
        if (found && live_any) begin
          sg_valid = 1'b1;
          sg_code  = rd_q.codes[CODE_W*live_sel +: CODE_W];
        end
      end
      OP_FAIL: begin
        sg_found = found;
        if (found && !rd_q.success && live_any) begin
          sg_rec.retry[CNT_W*live_sel +: CNT_W] = live_cnt - CNT_W'(1);
          sg_we = 1'b1;
        end
      end
      OP_SUCCESS: begin
        sg_found = found;
        if (found) begin
          sg_rec.success = 1'b1;
          sg_we          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sweep operations: reload counters and clear success, or clear counters by poll code.
  always_comb begin
    sw_rec = rd_q;
    if (op_q == OP_RESET_ALL) begin
      sw_rec.retry   = full_cnt;
      sw_rec.success = 1'b0;
    end else if (op_q == OP_DEACTIVATE) begin
      if (level_q == LVL_5X || level_q == LVL_4X || level_q == LVL_3X) begin
        if (rd_q.codes[0 +: CODE_W] == CODE_6F) begin
          sw_rec.retry[0 +: CNT_W] = '0;
        end
        if ((level_q == LVL_4X || level_q == LVL_3X) &&
            rd_q.codes[CODE_W +: CODE_W] == CODE_2F) begin
          sw_rec.retry[CNT_W +: CNT_W] = '0;
        end
        if (level_q == LVL_3X &&
            (rd_q.codes[0 +: CODE_W] == CODE_2A || rd_q.codes[0 +: CODE_W] == CODE_2B)) begin
          sw_rec.retry[0 +: CNT_W] = '0;
        end
      end
    end
  end

  // Memory port selection.
  assign mem_re    = cmd_i.rd_input || cmd_i.rd_sweep;
  assign mem_raddr = cmd_i.rd_sweep ? sweep_q : entry_index_i[IDX_W-1:0];
  assign mem_we    = (cmd_i.wr_single && sg_we) || (cmd_i.wr_sweep && present_q[sweep_q]);
  assign mem_waddr = cmd_i.wr_sweep ? sweep_q : idx_q[IDX_W-1:0];
  assign mem_wdata = cmd_i.wr_sweep ? sw_rec : sg_rec;

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Result register towards the output channel.
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_single || cmd_i.out_zero) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_single) begin
      found_q  <= sg_found;
      pvalid_q <= sg_valid;
      pcode_q  <= sg_code;
    end else if (cmd_i.out_zero) begin
      found_q  <= 1'b0;
      pvalid_q <= 1'b0;
      pcode_q  <= '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_found_o = found_q;
  assign poll_valid_o  = pvalid_q;
  assign poll_code_o   = pcode_q;

endmodule

// File: rtl/core/pftr_ctrl.sv
// ----------------------------------------------------------------------------
// Poll fallback retry table controller
// State machine that sequences the single-entry read-modify-write, the
// table sweeps and the hand-over of each result to the output register.
// ----------------------------------------------------------------------------
module pftr_ctrl import pftr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [2:0]  opcode_i,
  output logic        in_stall_o,
  output pftr_cmd_t   cmd_o,
  input  pftr_stat_t  stat_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SINGLE = 5'b00010,
    S_SW_RD  = 5'b00100,
    S_SW_WR  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture  = 1'b1;
          cmd_o.rd_input = 1'b1;
          if (opcode_i == OP_ADD || opcode_i == OP_GET ||
              opcode_i == OP_FAIL || opcode_i == OP_SUCCESS) begin
            state_d = S_SINGLE;
          end else if (opcode_i == OP_RESET_ALL || opcode_i == OP_DEACTIVATE) begin
            cmd_o.sweep_clr = 1'b1;
            state_d         = S_SW_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SINGLE: begin
        if (stat_i.out_free) begin
          cmd_o.wr_single  = 1'b1;
          cmd_o.out_single = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SW_RD: begin
        cmd_o.rd_sweep = 1'b1;
        state_d        = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.wr_sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.sweep_inc = 1'b1;
          state_d         = S_SW_RD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_zero = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // A result is only loaded when the output register can take it.
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_single || cmd_o.out_zero) |-> stat_i.out_free)
    else $error("result loaded while the output register is occupied");

  // Once an item is taken, no further item is taken in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input taken again directly after an accepted transaction");

  // The last sweep write always leads to the result state.
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_sweep && stat_i.sweep_last) |=> (state_q == S_DONE))
    else $error("sweep did not finish after the last entry");

  // Entry memory is never written by both a single operation and a sweep.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_single && cmd_o.wr_sweep))
    else $error("two writers on the entry memory");
`endif

endmodule

// File: rtl/core/poll_fallback_retry_table_core.sv
// ----------------------------------------------------------------------------
// Poll fallback retry table
// Per-meter table of four fallback poll codes with retry counters and a
// success flag, serving add, get, fail, success, reset-all and deactivate.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. Add, get, fail and success read
// the entry from the table memory in the cycle of acceptance; the
// single-operation state then writes it back and loads the result into the
// output register. Reset-all and deactivate sweep every entry with a read
// and, for entries that are present, a write, then load a zero result; unused
// opcodes go straight to the zero result. Each transaction gives exactly one
// result. The input side is free again as soon as a result is loaded into the
// output register; while the receiver stalls with a result still waiting
// there, the next transaction is held in its final state until the output
// register is free.
module poll_fallback_retry_table_core import pftr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic [ENTRY_W-1:0]  entry_index_i,
  input  logic [CODE_W-1:0]   primary_code_i,
  input  logic [CODE_W-1:0]   secondary_code_i,
  input  logic [CODE_W-1:0]   fallback_code_i,
  input  logic [CODE_W-1:0]   last_fallback_code_i,
  input  logic [1:0]          protocol_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                entry_found_o,
  output logic                poll_valid_o,
  output logic [CODE_W-1:0]   poll_code_o
);

  pftr_cmd_t  cmd;
  pftr_stat_t stat;

  // The retry register is always ready for a write.
  assign cfg_ready_o = 1'b1;

  pftr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  pftr_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .cfg_valid_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .opcode_i             (opcode_i),
    .entry_index_i        (entry_index_i),
    .primary_code_i       (primary_code_i),
    .secondary_code_i     (secondary_code_i),
    .fallback_code_i      (fallback_code_i),
    .last_fallback_code_i (last_fallback_code_i),
    .protocol_level_i     (protocol_level_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .entry_found_o        (entry_found_o),
    .poll_valid_o         (poll_valid_o),
    .poll_code_o          (poll_code_o)
  );

endmodule

// File: bench/tb_poll_fallback_retry_table_core.sv
// ----------------------------------------------------------------------------
// Poll fallback retry table testbench
// Drives add, get, fail, success, reset-all and deactivate transactions into
// the table core and compares every result with a cycle-free model of the
// table kept here or with a directed row's own result. A short directed table
// comes first, then random traffic with many add-then-exhaust sequences, under
// several retry settings and idling patterns on the input and output sides.
// ----------------------------------------------------------------------------
module tb_poll_fallback_retry_table_core;
  import pftr_pkg::*;

  // Opcodes and level with no function in the block.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [1:0] LVL_NONE  = 2'd3;

  localparam int POOL_N      = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 4000;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [ENTRY_W-1:0] entry;
    logic [CODE_W-1:0]  pri;
    logic [CODE_W-1:0]  sec;
    logic [CODE_W-1:0]  fb;
    logic [CODE_W-1:0]  lfb;
    logic [1:0]         level;
  } poll_req_t;

  typedef struct packed {
    logic              found;
    logic              pvalid;
    logic [CODE_W-1:0] code;
  } poll_rsp_t;

  typedef struct packed {
    poll_req_t req;
    logic      typed;
    poll_rsp_t rsp;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          opcode_i;
  logic [ENTRY_W-1:0]  entry_index_i;
  logic [CODE_W-1:0]   primary_code_i;
  logic [CODE_W-1:0]   secondary_code_i;
  logic [CODE_W-1:0]   fallback_code_i;
  logic [CODE_W-1:0]   last_fallback_code_i;
  logic [1:0]          protocol_level_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                entry_found_o;
  logic                poll_valid_o;
  logic [CODE_W-1:0]   poll_code_o;

  poll_fallback_retry_table_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .opcode_i             (opcode_i),
    .entry_index_i        (entry_index_i),
    .primary_code_i       (primary_code_i),
    .secondary_code_i     (secondary_code_i),
    .fallback_code_i      (fallback_code_i),
    .last_fallback_code_i (last_fallback_code_i),
    .protocol_level_i     (protocol_level_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .entry_found_o        (entry_found_o),
    .poll_valid_o         (poll_valid_o),
    .poll_code_o          (poll_code_o)
  );

  // Model of the table contents and the retry register.
  bit                     mdl_present [TABLE_DEPTH];
  logic [SLOTS*CODE_W-1:0] mdl_codes  [TABLE_DEPTH];
  logic [SLOTS*CNT_W-1:0]  mdl_counts [TABLE_DEPTH];
  bit                     mdl_success [TABLE_DEPTH];
  logic [CNT_W-1:0]       mdl_retry;

  poll_rsp_t pending_polls [$];
  int        mismatch_count;
  int        items_sent;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        hold_seq;
  int        hold_seen;
  int        hold_left;
  int        stuck_cycles;
  int        pool [POOL_N];

  // Directed rows; the retry register holds its reset value of three here.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{OP_GET, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_ADD, 8'd0, CODE_6F, CODE_2F, CODE_2A, CODE_2B, LVL_5X}, 1'b1,
      '{1'b1, 1'b0, 8'h00}},
    '{'{OP_ADD, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LVL_NONE}, 1'b1,
      '{1'b1, 1'b0, 8'h00}},
    '{'{OP_ADD, 8'd1, CODE_2A, CODE_2F, 8'h00, 8'h11, LVL_5X}, 1'b1,
      '{1'b1, 1'b0, 8'h00}},
    '{'{OP_ADD, 8'd2, CODE_2B, 8'h00, 8'h55, 8'hAA, LVL_5X}, 1'b1,
      '{1'b1, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1, '{1'b1, 1'b1, CODE_6F}},
    '{'{OP_GET, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1, '{1'b1, 1'b1, 8'hFF}},
    '{'{OP_FAIL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_SUCCESS, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1,
      '{1'b1, 1'b0, 8'h00}},
    '{'{OP_FAIL, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1, '{1'b1, 1'b0, 8'h00}},
    '{'{OP_SPARE6, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_SPARE7, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LVL_NONE}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_DEACTIVATE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_NONE}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_DEACTIVATE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_DEACTIVATE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_4X}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_DEACTIVATE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_3X}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_RESET_ALL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1,
      '{1'b0, 1'b0, 8'h00}},
    '{'{OP_GET, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b0, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_FAIL, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{OP_SUCCESS, 8'd200, 8'h00, 8'h00, 8'h00, 8'h00, LVL_5X}, 1'b1,
      '{1'b0, 1'b0, 8'h00}}
  };

  // Clock with a period of two units.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Index of the first slot whose counter is nonzero, or SLOTS if none is.
  function automatic int first_live_slot(int idx);
    for (int s = 0; s < SLOTS; s++) begin
      if (mdl_counts[idx][s*CNT_W +: CNT_W] != '0) return s;
    end
    return SLOTS;
  endfunction

  // Applies one transaction to the table model and returns its result.
  function automatic poll_rsp_t apply_table_op(poll_req_t r);
    poll_rsp_t        rsp;
    int               idx;
    int               slot;
    bit               hit;
    logic [CODE_W-1:0] p;
    logic [CODE_W-1:0] q;
    rsp  = '0;
    idx  = int'(r.entry);
    hit  = (idx < TABLE_DEPTH) && mdl_present[idx];
    case (r.opcode)
      OP_ADD: begin
        if (idx < TABLE_DEPTH) begin
          mdl_codes[idx]   = {r.lfb, r.fb, r.sec, r.pri};
          mdl_counts[idx]  = {SLOTS{mdl_retry}};
          mdl_success[idx] = 1'b0;
          mdl_present[idx] = 1'b1;
          rsp.found        = 1'b1;
        end
      end
      OP_GET: begin
        if (hit) begin
          rsp.found = 1'b1;
          slot = first_live_slot(idx);
          if (slot < SLOTS) begin
            rsp.pvalid = 1'b1;
            rsp.code   = mdl_codes[idx][slot*CODE_W +: CODE_W];
          end
        end
      end
      OP_FAIL: begin
        if (hit) begin
          rsp.found = 1'b1;
          slot = first_live_slot(idx);
          if (!mdl_success[idx] && slot < SLOTS) begin
            mdl_counts[idx][slot*CNT_W +: CNT_W] =
              mdl_counts[idx][slot*CNT_W +: CNT_W] - 1'b1;
          end
        end
      end
      OP_SUCCESS: begin
        if (hit) begin
          rsp.found        = 1'b1;
          mdl_success[idx] = 1'b1;
        end
      end
      OP_RESET_ALL: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (mdl_present[i]) begin
            mdl_counts[i]  = {SLOTS{mdl_retry}};
            mdl_success[i] = 1'b0;
          end
        end
      end
      OP_DEACTIVATE: begin
        // Each level includes the clearing rules of the levels below it.
        if (r.level != LVL_NONE) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (mdl_present[i]) begin
              p = mdl_codes[i][0 +: CODE_W];
              q = mdl_codes[i][CODE_W +: CODE_W];
              if (p == CODE_6F) mdl_counts[i][0 +: CNT_W] = '0;
              if (r.level >= LVL_4X && q == CODE_2F) mdl_counts[i][CNT_W +: CNT_W] = '0;
              if (r.level >= LVL_3X && (p == CODE_2A || p == CODE_2B))
                mdl_counts[i][0 +: CNT_W] = '0;
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Code for an add: often one of the codes that the deactivate sweep looks for.
  function automatic logic [CODE_W-1:0] pick_poll_code();
    case ($urandom_range(0, 9))
      0: return CODE_6F;
      1: return CODE_2F;
      2: return CODE_2A;
      3: return CODE_2B;
      default: return CODE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic poll_req_t make_request(logic [2:0] op, int idx);
    poll_req_t r;
    r.opcode = op;
    r.entry  = ENTRY_W'(idx);
    r.pri    = pick_poll_code();
    r.sec    = pick_poll_code();
    r.fb     = pick_poll_code();
    r.lfb    = pick_poll_code();
    r.level  = 2'($urandom_range(0, 3));
    return r;
  endfunction

  // Offers one transaction, waits for it to be taken and records its result.
  task automatic offer_request(poll_req_t r, bit typed = 1'b0, poll_rsp_t typed_rsp = '0);
    poll_rsp_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    opcode_i             <= r.opcode;
    entry_index_i        <= r.entry;
    primary_code_i       <= r.pri;
    secondary_code_i     <= r.sec;
    fallback_code_i      <= r.fb;
    last_fallback_code_i <= r.lfb;
    protocol_level_i     <= r.level;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = apply_table_op(r);
    pending_polls.push_back(typed ? typed_rsp : predicted);
    items_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_polls.size() != 0) @(posedge clk_i);
  endtask

  // Writes the retry register while the block is idle.
  task automatic write_retry(logic [CNT_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    mdl_retry = value;
  endtask

  // Random traffic, with many add-then-exhaust sequences, mostly on a few entries.
  task automatic run_random_traffic(int count);
    int        target;
    int        idx;
    int        fails;
    int        pick;
    poll_req_t r;
    target = items_sent + count;
    while (items_sent < target) begin
      idx  = pool[$urandom_range(0, POOL_N - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Add, then a random number of fails, often enough to run out the codes, with gets in between.
        offer_request(make_request(OP_ADD, idx));
        fails = $urandom_range(2, 4 * int'(mdl_retry) + 3);
        for (int k = 0; k < fails; k++) begin
          offer_request(make_request(OP_FAIL, idx));
          if ($urandom_range(0, 1)) offer_request(make_request(OP_GET, idx));
        end
        offer_request(make_request(OP_GET, idx));
      end else if (pick < 45) begin
        // A success must freeze the counters against later fails.
        offer_request(make_request(OP_SUCCESS, idx));
        offer_request(make_request(OP_FAIL, idx));
        offer_request(make_request(OP_GET, idx));
      end else if (pick < 93) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      r = make_request(OP_ADD, idx);
        else if (pick < 50) r = make_request(OP_GET, idx);
        else if (pick < 80) r = make_request(OP_FAIL, idx);
        else if (pick < 90) r = make_request(OP_SUCCESS, idx);
        else if (pick < 93) r = make_request(OP_RESET_ALL, idx);
        else if (pick < 98) r = make_request(OP_DEACTIVATE, idx);
        else                r = make_request(3'($urandom_range(6, 7)), idx);
        offer_request(r);
      end else begin
        // Noise: any opcode on any entry.
        offer_request(make_request(3'($urandom_range(0, 7)), $urandom_range(0, 255)));
      end
    end
  endtask

  // Output side: stalls at random, or holds off for a long stretch on request.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      out_stall_i <= 1'b1;
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Result checker: each transaction on the output is compared with the oldest
  // expectation.
  always @(posedge clk_i) begin
    poll_rsp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_polls.size() == 0) begin
        $display("%0t: result with none expected: found %b valid %b code %h",
                 $time, entry_found_o, poll_valid_o, poll_code_o);
        mismatch_count++;
      end else begin
        want = pending_polls.pop_front();
        if (entry_found_o !== want.found) begin
          $display("%0t: entry_found expected %b actual %b",
                   $time, want.found, entry_found_o);
          mismatch_count++;
        end
        if (poll_valid_o !== want.pvalid) begin
          $display("%0t: poll_valid expected %b actual %b",
                   $time, want.pvalid, poll_valid_o);
          mismatch_count++;
        end
        if (poll_code_o !== want.code) begin
          $display("%0t: poll_code expected %h actual %h",
                   $time, want.code, poll_code_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst_ni               <= 1'b0;
    cfg_valid_i          <= 1'b0;
    cfg_data_i           <= '0;
    in_valid_i           <= 1'b0;
    opcode_i             <= OP_GET;
    entry_index_i        <= '0;
    primary_code_i       <= '0;
    secondary_code_i     <= '0;
    fallback_code_i      <= '0;
    last_fallback_code_i <= '0;
    protocol_level_i     <= LVL_5X;
    out_stall_i          <= 1'b1;
    mismatch_count = 0;
    items_sent     = 0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    stuck_cycles   = 0;
    tx_idle_pct    = 9;
    rx_idle_pct    = 75;
    mdl_retry      = RETRY_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      mdl_present[i] = 1'b0;
      mdl_success[i] = 1'b0;
      mdl_codes[i]   = '0;
      mdl_counts[i]  = '0;
    end
    pool[0] = 0;
    pool[1] = 255;
    for (int i = 2; i < POOL_N; i++) pool[i] = $urandom_range(1, 254);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset value of the retry register.
    for (int i = 0; i < DIR_ROWS; i++)
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // Largest retry count, with a mostly stalled receiver.
    write_retry(4'd15);
    run_random_traffic(380);

    // Zero and one, with the sender mostly idle instead.
    tx_idle_pct = 75;
    rx_idle_pct = 9;
    write_retry(4'd0);
    run_random_traffic(100);
    write_retry(4'd1);
    run_random_traffic(140);
    wait_drained();
    run_random_traffic(140);

    // No idling on either side; the receiver first holds off for a long stretch.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_retry(CNT_W'($urandom_range(2, 14)));
    hold_seq++;
    run_random_traffic(390);

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
